>>> hw/rtl/egcd_pkg.sv
`default_nettype none
package egcd_pkg;
   localparam int DataWidth = 64;
   localparam int CntWidth  = $clog2(DataWidth + 1);

   typedef logic [DataWidth-1:0] word_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic mul_step;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic b_zero;
      logic div_last;
      logic mul_last;
   } status_type;
endpackage
`default_nettype wire

>>> hw/rtl/egcd_datapath.sv
`default_nettype none
module egcd_datapath (
   input  wire logic                clock,
   input  wire egcd_pkg::cmd_type   cmd,
   output egcd_pkg::status_type     status,
   input  wire egcd_pkg::word_type  load_a,
   input  wire egcd_pkg::word_type  load_b,
   output egcd_pkg::word_type       res_r,
   output egcd_pkg::word_type       res_s,
   output egcd_pkg::word_type       res_t
);
   localparam int W = egcd_pkg::DataWidth;

   egcd_pkg::word_type a_ff, b_ff, s0_ff, s1_ff, t0_ff, t1_ff;
   egcd_pkg::word_type a_in, b_in, s0_in, s1_in, t0_in, t1_in;
   // divider: magnitude quotient/remainder, shift-subtract
   egcd_pkg::word_type rem_ff, rem_in, quo_ff, quo_in, mb_ff, mb_in;
   egcd_pkg::word_type q_ff, q_in;
   logic [egcd_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   // multiplier: shift-add, both products at once
   egcd_pkg::word_type ps_ff, ps_in, pt_ff, pt_in, mq_ff, mq_in;

   logic [W:0] trial;
   egcd_pkg::word_type ma, mbv, rsgn;
   logic neg_q;

   always_comb begin
      ma  = a_ff[W-1] ? -a_ff : a_ff;
      mbv = b_ff[W-1] ? -b_ff : b_ff;
      neg_q = a_ff[W-1] ^ b_ff[W-1];
      trial = {rem_ff, quo_ff[W-1]} - {1'b0, mb_ff};
      rsgn  = a_ff[W-1] ? -rem_ff : rem_ff;

      a_in = a_ff; b_in = b_ff; s0_in = s0_ff; s1_in = s1_ff;
      t0_in = t0_ff; t1_in = t1_ff;
      rem_in = rem_ff; quo_in = quo_ff; mb_in = mb_ff; cnt_in = cnt_ff;
      q_in = q_ff; ps_in = ps_ff; pt_in = pt_ff; mq_in = mq_ff;

      if (cmd.load) begin
         a_in = load_a; b_in = load_b;
         s0_in = W'(1); s1_in = '0; t0_in = '0; t1_in = W'(1);
      end
      if (cmd.div_start) begin
         rem_in = '0; quo_in = ma; mb_in = mbv;
         cnt_in = egcd_pkg::CntWidth'(W);
      end
      if (cmd.div_step) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == egcd_pkg::CntWidth'(1)) begin
            ps_in = '0; pt_in = '0;
            cnt_in = egcd_pkg::CntWidth'(W + 1);
         end
      end
      if (cmd.mul_step) begin
         // mq takes the signed quotient, consumed msb first; q takes the signed remainder
         if (cnt_ff == egcd_pkg::CntWidth'(W + 1)) begin
            mq_in = neg_q ? -quo_ff : quo_ff;
            q_in  = rsgn;
            ps_in = '0; pt_in = '0;
            cnt_in = egcd_pkg::CntWidth'(W);
         end else begin
            mq_in = {mq_ff[W-2:0], 1'b0};
            ps_in = {ps_ff[W-2:0], 1'b0} + (mq_ff[W-1] ? s1_ff : '0);
            pt_in = {pt_ff[W-2:0], 1'b0} + (mq_ff[W-1] ? t1_ff : '0);
            cnt_in = cnt_ff - 1'b1;
         end
      end
      if (cmd.update) begin
         s0_in = s1_ff; s1_in = s0_ff - ps_ff;
         t0_in = t1_ff; t1_in = t0_ff - pt_ff;
         a_in = b_ff; b_in = q_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; s0_ff <= s0_in; s1_ff <= s1_in;
      t0_ff <= t0_in; t1_ff <= t1_in; rem_ff <= rem_in; quo_ff <= quo_in;
      mb_ff <= mb_in; cnt_ff <= cnt_in; q_ff <= q_in;
      ps_ff <= ps_in; pt_ff <= pt_in; mq_ff <= mq_in;
   end

   assign status.b_zero   = (b_ff == '0);
   assign status.div_last = (cnt_ff == egcd_pkg::CntWidth'(1));
   assign status.mul_last = (cnt_ff == egcd_pkg::CntWidth'(1));
   assign res_r = a_ff;
   assign res_s = s0_ff;
   assign res_t = t0_ff;
endmodule
`default_nettype wire

>>> hw/rtl/egcd_ctrl.sv
`default_nettype none
module egcd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire egcd_pkg::status_type status,
   output egcd_pkg::cmd_type         cmd
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StTest = 3'd1;
   localparam logic [2:0] StDiv  = 3'd2;
   localparam logic [2:0] StMul  = 3'd3;
   localparam logic [2:0] StUpd  = 3'd4;
   localparam logic [2:0] StDone = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         StIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StTest;
            end
         end
         StTest: begin
            if (status.b_zero) state_in = StDone;
            else begin
               cmd.div_start = 1'b1;
               state_in = StDiv;
            end
         end
         StDiv: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = StMul;
         end
         StMul: begin
            cmd.mul_step = 1'b1;
            if (status.mul_last) state_in = StUpd;
         end
         StUpd: begin
            cmd.update = 1'b1;
            state_in = StTest;
         end
         StDone: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= StIdle;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

>>> hw/rtl/extended_gcd.sv
// sequence: once the request is taken, each euclid iteration runs a test, 64 divide
// steps, a quotient load and 64 multiply steps, and a coefficient update; the
// response is valid once the test finds the remainder zero
// throughput: one request at a time, next accepted the cycle after the response is taken
// reset: synchronous active-high reset returns the controller to idle
`default_nettype none
module extended_gcd (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_operand_a,
   input  wire logic [63:0] req_operand_b,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_divisor_out,
   output logic [63:0]      rsp_coef_a,
   output logic [63:0]      rsp_coef_b
);
   egcd_pkg::cmd_type    cmd;
   egcd_pkg::status_type status;
   egcd_pkg::word_type   res_r, res_s, res_t;

   // controller sequences divide, multiply and coefficient update
   egcd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   // datapath holds the running remainder pair and coefficient pairs
   // operands use the low datapath-width bits, results are sign-extended to 64
   egcd_datapath u_dp (
      .clock, .cmd, .status,
      .load_a(req_operand_a[egcd_pkg::DataWidth-1:0]),
      .load_b(req_operand_b[egcd_pkg::DataWidth-1:0]),
      .res_r, .res_s, .res_t
   );

   assign rsp_divisor_out = 64'(signed'(res_r));
   assign rsp_coef_a      = 64'(signed'(res_s));
   assign rsp_coef_b      = 64'(signed'(res_t));
endmodule
`default_nettype wire
